FILE: rtl/rsm_pkg.sv
// Shared types, constants and exponent tables for the row softmax unit.
package rsm_pkg;

   localparam int RowLenDefault = 64;
   localparam int DataWidth     = 16;
   localparam int ExpWidth      = 17;
   localparam int SumWidth      = 32;
   localparam int InvWidth      = 33;
   localparam int DivSteps      = 49;
   localparam int FlushLimit    = -4096;
   localparam logic [16:0] Log2eQ16 = 17'd94548;

   typedef enum logic [3:0] {
      ST_LOAD, ST_RD, ST_EXPD, ST_M1, ST_M2, ST_SH, ST_ACC, ST_DIV, ST_NP1, ST_NP2, ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic acc;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic row_end;
      logic idx_last;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [16:0] coarse_tab(input logic [3:0] k);
      logic [16:0] r;
      unique case (k)
         4'd0: r = 17'd65536;   4'd1: r = 17'd62757;   4'd2: r = 17'd60097;
         4'd3: r = 17'd57549;   4'd4: r = 17'd55109;   4'd5: r = 17'd52773;
         4'd6: r = 17'd50535;   4'd7: r = 17'd48393;   4'd8: r = 17'd46341;
         4'd9: r = 17'd44376;   4'd10: r = 17'd42495;  4'd11: r = 17'd40693;
         4'd12: r = 17'd38968;  4'd13: r = 17'd37316;  4'd14: r = 17'd35734;
         default: r = 17'd34219;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] fine_tab(input logic [3:0] k);
      logic [16:0] r;
      unique case (k)
         4'd0: r = 17'd65536;   4'd1: r = 17'd65359;   4'd2: r = 17'd65182;
         4'd3: r = 17'd65006;   4'd4: r = 17'd64830;   4'd5: r = 17'd64655;
         4'd6: r = 17'd64480;   4'd7: r = 17'd64306;   4'd8: r = 17'd64132;
         4'd9: r = 17'd63958;   4'd10: r = 17'd63785;  4'd11: r = 17'd63613;
         4'd12: r = 17'd63441;  4'd13: r = 17'd63270;  4'd14: r = 17'd63099;
         default: r = 17'd62928;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/rsm_ram.sv
// Generic single-port-write, registered-read RAM.
module rsm_ram #(
   parameter int Width = 16,
   parameter int Depth = 64,
   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AddrWidth-1:0] waddr,
   input  logic [Width-1:0]     wdata,
   input  logic [AddrWidth-1:0] raddr,
   output logic [Width-1:0]     rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/rsm_ctrl.sv
// Controller state machine sequencing load, sum, reciprocal and output.
module rsm_ctrl import rsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      norm_ff, norm_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         norm_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         norm_ff  <= norm_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      norm_in  = norm_ff;
      unique case (state_ff)
         ST_LOAD: if (req_valid && status.row_end) state_in = ST_RD;
         ST_RD:   state_in = ST_EXPD;
         ST_EXPD: state_in = ST_M1;
         ST_M1:   state_in = ST_M2;
         ST_M2:   state_in = ST_SH;
         ST_SH:   state_in = norm_ff ? ST_NP1 : ST_ACC;
         ST_ACC:  state_in = status.idx_last ? ST_DIV : ST_RD;
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_RD;
               norm_in  = 1'b1;
            end
         end
         ST_NP1:  state_in = ST_NP2;
         ST_NP2:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               if (status.idx_last) begin
                  state_in = ST_LOAD;
                  norm_in  = 1'b0;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != ST_LOAD);
      cmd.load     = (state_ff == ST_LOAD) && req_valid;
      cmd.acc      = (state_ff == ST_ACC);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.emit     = (state_ff == ST_EMIT) && status.out_free;
   end
endmodule

FILE: rtl/rsm_datapath.sv
// Datapath: row store, max tracking, exp unit, sum, reciprocal and scaling.
module rsm_datapath import rsm_pkg::*; #(
   parameter int RowLen = RowLenDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [DataWidth-1:0] req_value,
   input  logic                        req_last,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [DataWidth-1:0]        rsp_prob,
   output logic                        rsp_last_out,
   input  cmd_type                     cmd,
   output status_type                  status
);
   localparam int AW = (RowLen > 1) ? $clog2(RowLen) : 1;
   localparam int CW = $clog2(RowLen + 1);

   logic [CW-1:0]               fill_ff, fill_in, idx_ff, idx_in;
   logic signed [DataWidth-1:0] max_ff, max_in;
   logic [SumWidth-1:0]         sum_ff, sum_in;
   logic [DataWidth-1:0]        q;

   logic signed [16:0] d;
   logic [12:0]        e_ff;
   logic               flush_ff, fl1_ff, fl2_ff;
   logic [29:0]        eprod;
   logic [12:0]        u_ff;
   logic [4:0]         ip_ff;
   logic [33:0]        cf;
   logic [16:0]        m_ff;
   logic [ExpWidth-1:0] exp_ff;

   logic [5:0]          dcnt_ff, dcnt_in;
   logic [InvWidth-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [InvWidth:0]   rem_sh;
   logic [InvWidth-1:0] inv;
   logic [32:0]         plo_ff;
   logic [33:0]         phi_ff;
   logic [50:0]         tot;
   logic [18:0]         pfull;

   logic                 vld_ff, vld_in, last_o_ff;
   logic [DataWidth-1:0] prob_ff;

   rsm_ram #(.Width(DataWidth), .Depth(RowLen)) u_store (
      .clock (clock),
      .we    (cmd.load),
      .waddr (fill_ff[AW-1:0]),
      .wdata (req_value),
      .raddr (idx_ff[AW-1:0]),
      .rdata (q)
   );

   assign status.row_end  = req_last || (fill_ff == CW'(RowLen - 1));
   assign status.idx_last = ((idx_ff + CW'(1)) == fill_ff);
   assign status.div_done = (dcnt_ff == 6'd0);
   assign status.out_free = !vld_ff || !rsp_stall;

   // exp pipeline runs every cycle; the controller waits for it to settle
   assign d     = 17'(signed'(q)) - 17'(max_ff);
   assign eprod = 30'(e_ff) * 30'(Log2eQ16) + 30'd32768;
   assign cf    = 34'(coarse_tab(u_ff[7:4])) * 34'(fine_tab(u_ff[3:0])) + 34'd32768;

   always_ff @(posedge clock) begin
      flush_ff <= (d < 17'sd0 + 17'(FlushLimit));
      e_ff     <= 13'(-d);
      fl1_ff   <= flush_ff;
      u_ff     <= eprod[28:16];
      fl2_ff   <= fl1_ff;
      ip_ff    <= u_ff[12:8];
      m_ff     <= cf[32:16];
      exp_ff   <= fl2_ff ? '0 : (m_ff >> ip_ff);
      plo_ff   <= 33'(exp_ff) * 33'(inv[15:0]);
      phi_ff   <= 34'(exp_ff) * 34'(inv[32:16]);
   end

   assign inv   = (sum_ff == '0) ? '0 : quo_ff;
   assign tot   = {1'b0, phi_ff, 16'd0} + 51'(plo_ff) + 51'(64'h8000_0000);
   assign pfull = tot[50:32];

   // restoring division of 2^48 by the sum, one quotient bit a cycle
   assign rem_sh = {rem_ff, (dcnt_ff == 6'(DivSteps - 1))};

   always_comb begin
      fill_in = fill_ff;
      idx_in  = idx_ff;
      max_in  = max_ff;
      sum_in  = sum_ff;
      dcnt_in = dcnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      vld_in  = vld_ff && rsp_stall;
      if (cmd.load) begin
         fill_in = fill_ff + CW'(1);
         if (req_value > max_ff) max_in = req_value;
      end
      if (cmd.acc) begin
         sum_in = sum_ff + SumWidth'(exp_ff);
         idx_in = status.idx_last ? '0 : idx_ff + CW'(1);
         rem_in  = '0;
         quo_in  = '0;
         dcnt_in = 6'(DivSteps - 1);
      end
      if (cmd.div_step) begin
         if (rem_sh >= {2'b0, sum_ff}) begin
            rem_in = InvWidth'(rem_sh - {2'b0, sum_ff});
            quo_in = {quo_ff[InvWidth-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[InvWidth-1:0];
            quo_in = {quo_ff[InvWidth-2:0], 1'b0};
         end
         if (dcnt_ff != 6'd0) dcnt_in = dcnt_ff - 6'd1;
      end
      if (cmd.emit) begin
         vld_in = 1'b1;
         if (status.idx_last) begin
            idx_in  = '0;
            fill_in = '0;
            max_in  = -16'sd32768;
            sum_in  = '0;
         end else begin
            idx_in = idx_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         idx_ff  <= '0;
         max_ff  <= -16'sd32768;
         sum_ff  <= '0;
         dcnt_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         idx_ff  <= idx_in;
         max_ff  <= max_in;
         sum_ff  <= sum_in;
         dcnt_ff <= dcnt_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.emit) begin
         prob_ff   <= (pfull > 19'd65535) ? 16'hFFFF : pfull[15:0];
         last_o_ff <= status.idx_last;
      end
   end

   assign rsp_valid    = vld_ff;
   assign rsp_prob     = prob_ff;
   assign rsp_last_out = last_o_ff;
endmodule

FILE: rtl/row_softmax_unit_core.sv
// Top level of the row softmax unit.
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_value, req_last
//  rsp     | out       | rsp_valid, rsp_stall, rsp_prob, rsp_last_out
// Loading accepts one element per cycle. After the last element each element
// passes the exp pipeline twice, once while summing and once while emitting,
// with a bit-serial reciprocal between. Reset is synchronous and clears the row.
// req_stall is high from the row end until the last result is loaded into the
// output register; rsp_stall holds it.
module row_softmax_unit_core import rsm_pkg::*; #(
   parameter int RowLen = RowLenDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DataWidth-1:0] req_value,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [DataWidth-1:0]        rsp_prob,
   output logic                        rsp_last_out
);
   cmd_type    cmd;
   status_type status;

   rsm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .status, .cmd
   );

   rsm_datapath #(.RowLen(RowLen)) u_dp (
      .clock, .reset, .req_value, .req_last, .rsp_stall,
      .rsp_valid, .rsp_prob, .rsp_last_out, .cmd, .status
   );
endmodule

FILE: rtl/rsm_checker.sv
// Port-level checker for the row softmax unit, bound to the top level.
module rsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_prob
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prob))
      else $error("stalled result changed");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input taken after row end");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("bad state after reset");
endmodule

bind row_softmax_unit_core rsm_checker u_rsm_checker (
   .clock, .reset, .req_valid, .req_stall, .req_last, .rsp_valid, .rsp_stall, .rsp_prob
);

FILE: dv/row_softmax_unit_core_checker.sv
// Checker for the row softmax unit: predicts probabilities per row and compares results.
module row_softmax_unit_core_checker import rsm_pkg::*; #(
   parameter int RowLen = RowLenDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [15:0]   req_value,
   input  logic                 req_last,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [15:0]          rsp_prob,
   input  logic                 rsp_last_out,
   output int                   fail_count,
   output int                   pending,
   output int                   rows_done
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] prob;
      logic        last_out;
   } prob_item_t;

   localparam logic [16:0] Coarse [16] = '{
      17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773, 17'd50535, 17'd48393,
      17'd46341, 17'd44376, 17'd42495, 17'd40693, 17'd38968, 17'd37316, 17'd35734, 17'd34219};
   localparam logic [16:0] Fine [16] = '{
      17'd65536, 17'd65359, 17'd65182, 17'd65006, 17'd64830, 17'd64655, 17'd64480, 17'd64306,
      17'd64132, 17'd63958, 17'd63785, 17'd63613, 17'd63441, 17'd63270, 17'd63099, 17'd62928};

   logic signed [15:0] row_vals [$];
   logic signed [15:0] cur_max;
   prob_item_t         expected_probs [$];
   int                 rsp_seen;

   function automatic logic [31:0] exp_of_diff(input int d);
      logic [31:0] e, u, ip, f;
      logic [63:0] m;
      if (d > 0) d = 0;
      if (d < FlushLimit) return 32'd0;
      e  = 32'(-d);
      u  = 32'((64'(e) * 64'd94548 + 64'd32768) >> 16);
      ip = u >> 8;
      f  = u & 32'd255;
      m  = (64'(Coarse[f[7:4]]) * 64'(Fine[f[3:0]]) + 64'd32768) >> 16;
      if (ip >= 32) return 32'd0;
      return 32'(m >> ip);
   endfunction

   task automatic predict_row();
      logic [31:0] sum;
      logic [63:0] inv, p, q;
      int n;
      prob_item_t it;
      n   = row_vals.size();
      sum = '0;
      for (int i = 0; i < n; i++) sum += exp_of_diff(int'(row_vals[i]) - int'(cur_max));
      inv = (sum != 0) ? ((64'd1 << 48) / 64'(sum)) : 64'd0;
      for (int i = 0; i < n; i++) begin
         q = 64'(exp_of_diff(int'(row_vals[i]) - int'(cur_max)));
         p = (q * inv + (64'd1 << 31)) >> 32;
         if (p > 64'd65535) p = 64'd65535;
         it.prob     = p[15:0];
         it.last_out = (i == n - 1);
         expected_probs.push_back(it);
      end
      row_vals.delete();
      cur_max = -16'sd32768;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH result %0d: %s got %0d expected %0d", rsp_seen, what, got, want);
      fail_count++;
   endtask

   assign pending = expected_probs.size();

   initial begin
      fail_count = 0;
      rows_done  = 0;
      rsp_seen   = 0;
      cur_max    = -16'sd32768;
   end

   always @(posedge clock) begin
      prob_item_t w;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            row_vals.push_back(req_value);
            if (req_value > cur_max) cur_max = req_value;
            if (req_last || row_vals.size() >= RowLen) begin
               predict_row();
               rows_done++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_probs.size() == 0) begin
               report_mismatch("unexpected prob", rsp_prob, -1);
            end else begin
               w = expected_probs.pop_front();
               if (rsp_prob !== w.prob) report_mismatch("prob", rsp_prob, w.prob);
               if (rsp_last_out !== w.last_out)
                  report_mismatch("last_out", rsp_last_out, w.last_out);
            end
            rsp_seen++;
         end
      end
   end
endmodule

FILE: dv/row_softmax_unit_core_tb.sv
// Testbench top for the row softmax unit: stimulus, back-pressure and verdict.
module row_softmax_unit_core_tb import rsm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RowLen    = 64;
   localparam int CycleCap  = 400000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, req_last = 0;
   logic signed [15:0] req_value = '0;
   logic rsp_valid, rsp_stall = 1, rsp_last_out;
   logic [15:0] rsp_prob;
   int fail_count, pending, rows_done;
   int cycles = 0, items_sent = 0;
   int stall_left = 0;
   bit hold_off = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   row_softmax_unit_core #(.RowLen(RowLen)) dut (.*);

   row_softmax_unit_core_checker #(.RowLen(RowLen)) chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleCap) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: mostly short random stalls, now and then a long one, or a hold-off when asked
   always @(posedge clock) begin
      if (reset || hold_off) rsp_stall <= 1'b1;
      else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 60) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(10, 60);
      end else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   task automatic send_elem(input logic [15:0] v, input bit lst);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_row(input int n, input int mode);
      logic [15:0] v;
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 2047) - 1024);
            default: v = 16'($urandom_range(0, 8191) - 4096);
         endcase
         send_elem(v, i == n - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // single element, a max/min pair, a flushed tail, ties
      send_elem(16'sh7FFF, 1'b1);
      send_elem(16'sh8000, 1'b1);
      send_elem(16'sh7FFF, 1'b0); send_elem(16'sh8000, 1'b1);
      send_elem(16'sh0000, 1'b0); send_elem(-16'sd4096, 1'b0); send_elem(-16'sd4097, 1'b1);
      send_elem(16'sh0100, 1'b0); send_elem(16'sh0100, 1'b0); send_elem(16'sh0100, 1'b1);
      send_elem(16'shFFFF, 1'b0); send_elem(16'sh0001, 1'b0); send_elem(16'sh5555, 1'b0);
      send_elem(16'shAAAA, 1'b1);
      drain();
      // row that fills every slot with no last flag
      for (int i = 0; i < RowLen; i++) send_elem(16'($urandom), 1'b0);
      drain();
      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_row(12, 1);
            send_row(5, 1);
         end
      join
      drain();
      while (items_sent < 230) begin
         send_row(($urandom_range(0, 7) == 0) ? $urandom_range(20, RowLen)
                                              : $urandom_range(1, 10),
                  $urandom_range(0, 2));
      end
      drain();
      $display("Sent %0d elements in %0d rows, incl. full-store rows, flushing and long stalls",
               items_sent, rows_done);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
